/* rtl/slq_pkg.sv */
// Shared types and codes for the sorted list queue.
// No dependencies; compiled first.
package slq_pkg;

  typedef enum logic [1:0] {
    KIND_SORTED   = 2'd0,
    KIND_APPEND   = 2'd1,
    KIND_POP_HEAD = 2'd2,
    KIND_POP_TAIL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast to every cell for the word being accepted this cycle.
  typedef struct packed {
    logic insert;    // insert that fits
    logic sorted;    // ordered insert (else append)
    logic pop_head;  // head removal on a non-empty list
  } cell_ctrl_t;

endpackage

/* rtl/slq_if.sv */
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing; follows slq_pkg in compile order.
interface slq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface slq_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] removed_value;
  logic        removed_valid;
  logic [1:0]  status;
  logic [4:0]  occupancy;

  modport source (output valid, output removed_value, output removed_valid,
                  output status, output occupancy, input ready);
  modport sink   (input valid, input removed_value, input removed_valid,
                  input status, input occupancy, output ready);
endinterface

/* rtl/slq_cell.sv */
// One list slot: holds an entry, compares it with the incoming value and
// takes its new entry from the value or a neighbor. Depends on slq_pkg.
module slq_cell (
  input  logic               clk,
  input  slq_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0] value,
  input  logic signed [31:0] left_entry,
  input  logic signed [31:0] right_entry,
  input  logic               occ,
  input  logic               at_tail,
  input  logic               found_before,
  output logic signed [31:0] entry,
  output logic               hit
);

  logic signed [31:0] entry_next;

  assign hit = occ && (entry >= value);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (ctrl.sorted) begin
        if (found_before && (occ || at_tail)) begin
          entry_next = left_entry;
        end else if (!found_before && (hit || at_tail)) begin
          entry_next = value;
        end
      end else if (at_tail) begin
        entry_next = value;
      end
    end else if (ctrl.pop_head && occ) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* rtl/sorted_list_queue.sv */
// Top level of the sorted list queue: a row of slq_cell slots plus count
// and response register. Depends on slq_pkg, slq_if and slq_cell.
//
// Usage: request words on req carry kind and value; every accepted request
// gives exactly one response word on rsp with removed_value, removed_valid,
// status and occupancy (entries stored after the operation).
// Sorted insert places the value ahead of the first entry >= it; append
// adds at the tail; the two removals take out the head or the tail.
// An insert on a full list is dropped with status full; a removal on an
// empty list changes nothing and reports status empty.
// The response is registered and shows in the cycle after accept.
// Throughput: one request per cycle while rsp is not stalled. Each cell
// compares in parallel and shifts by one slot in the same cycle; the
// insert position is a log2(DEPTH)-level prefix OR over the compare flags.
// The response register is the only buffer: while rsp is stalled, req.ready
// stays low and the list holds; a new word enters in the cycle the pending
// response is taken.
// Reset clears the count and the response valid; slot contents are left
// as they are, since only slots below the count are ever read.
module sorted_list_queue #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  slq_req_if.sink   req,
  slq_rsp_if.source rsp
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int IW  = $clog2(DEPTH);
  localparam int LVL = $clog2(DEPTH);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  logic          is_insert;
  slq_pkg::kind_t     kind;
  slq_pkg::cell_ctrl_t ctrl;

  logic signed [31:0] entry [DEPTH];
  logic [DEPTH-1:0]   hit;
  logic [DEPTH-1:0]   found_before;
  logic [DEPTH-1:0]   occ;
  logic [DEPTH-1:0]   at_tail;

  logic signed [31:0] tail_entry;
  logic signed [31:0] removed_next;
  logic               removed_valid_next;
  slq_pkg::status_t   status_next;

  assign kind      = slq_pkg::kind_t'(req.kind);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign is_insert = (kind == slq_pkg::KIND_SORTED) || (kind == slq_pkg::KIND_APPEND);
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign ctrl.insert   = accept && is_insert && !full;
  assign ctrl.sorted   = (kind == slq_pkg::KIND_SORTED);
  assign ctrl.pop_head = accept && (kind == slq_pkg::KIND_POP_HEAD) && !empty;

  // exclusive prefix OR of the hit flags: set above the first hit
  always_comb begin
    logic [DEPTH-1:0] p;
    p = hit << 1;
    for (int k = 0; k < LVL; k++) begin
      p = p | (p << (1 << k));
    end
    found_before = p;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_entry;
    logic signed [31:0] right_entry;

    assign occ[i]     = (CW'(i) < count);
    assign at_tail[i] = (CW'(i) == count);

    if (i == 0) begin : g_first
      assign left_entry = req.value;
    end else begin : g_mid_l
      assign left_entry = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_mid_r
      assign right_entry = entry[i+1];
    end

    slq_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .value        (req.value),
      .left_entry   (left_entry),
      .right_entry  (right_entry),
      .occ          (occ[i]),
      .at_tail      (at_tail[i]),
      .found_before (found_before[i]),
      .entry        (entry[i]),
      .hit          (hit[i])
    );
  end

  assign tail_entry = entry[IW'(count - CW'(1))];

  always_comb begin
    count_next         = count;
    removed_next       = '0;
    removed_valid_next = 1'b0;
    status_next        = slq_pkg::ST_DONE;
    if (is_insert) begin
      if (full) begin
        status_next = slq_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else if (empty) begin
      status_next = slq_pkg::ST_EMPTY;
    end else begin
      removed_valid_next = 1'b1;
      removed_next       = (kind == slq_pkg::KIND_POP_HEAD) ? entry[0] : tail_entry;
      count_next         = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.removed_value <= removed_next;
      rsp.removed_valid <= removed_valid_next;
      rsp.status        <= status_next;
      rsp.occupancy     <= 5'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == slq_pkg::ST_FULL) |-> rsp.occupancy == 5'(DEPTH))
    else $error("full status with list not full");

  a_removed_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.removed_valid |-> rsp.status == slq_pkg::ST_DONE)
    else $error("removed word with failure status");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    accept && !is_insert && empty |=> count == '0)
    else $error("removal on empty list changed count");

endmodule
